@@ design/sls_pkg.sv @@
package sls_pkg;

  // defaults for the top-level parameters
  localparam int MaxFeaturesDefault = 65536;
  localparam int WeightBitsDefault  = 24;

  // field widths fixed by the interface
  localparam int IndexBits  = 16;
  localparam int InWeightBits = 24;
  localparam int SumBits    = 32;
  localparam int ProbBits   = 16;
  localparam int CountBits  = 17;

  // reset value of the feature count register
  localparam logic [CountBits-1:0] FeatureCountReset = 17'h10000;

  // sigmoid clamp point, 8.0 in Q16.16
  localparam logic [19:0] SigClamp = 20'h80000;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // accumulate-stage controls
  typedef struct packed {
    logic add;
    logic fin;
    logic in_range;
  } acc_ctl_t;

  // finished-instance snapshot handed to the sigmoid
  typedef struct packed {
    logic                      valid;
    logic signed [SumBits-1:0] sum;
    logic                      err;
  } snap_t;

  // round(65536 * sigmoid(k/2)), k = 0..16; larger codes hold the last point
  function automatic logic [15:0] sig_point(input logic [4:0] k);
    logic [15:0] v;
    case (k)
      5'd0:    v = 16'd32768;
      5'd1:    v = 16'd40793;
      5'd2:    v = 16'd47911;
      5'd3:    v = 16'd53581;
      5'd4:    v = 16'd57724;
      5'd5:    v = 16'd60565;
      5'd6:    v = 16'd62428;
      5'd7:    v = 16'd63615;
      5'd8:    v = 16'd64357;
      5'd9:    v = 16'd64816;
      5'd10:   v = 16'd65097;
      5'd11:   v = 16'd65269;
      5'd12:   v = 16'd65374;
      5'd13:   v = 16'd65438;
      5'd14:   v = 16'd65476;
      5'd15:   v = 16'd65500;
      default: v = 16'd65514;
    endcase
    return v;
  endfunction

endpackage

@@ design/sls_ram.sv @@
module sls_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/sls_accum.sv @@
module sls_accum #(
  parameter int WEIGHT_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sls_pkg::acc_ctl_t             ctl,
  input  logic signed [WEIGHT_BITS-1:0] weight,
  output sls_pkg::snap_t                snap
);
  import sls_pkg::*;

  logic signed [SumBits-1:0] running_sum;
  logic                      error_seen;
  logic signed [SumBits:0]   wide_sum;
  logic signed [SumBits-1:0] sat_sum;

  // saturating add of the fetched weight
  always_comb begin
    wide_sum = (SumBits+1)'(running_sum) + (SumBits+1)'(weight);
    if (wide_sum[SumBits] != wide_sum[SumBits-1]) begin
      sat_sum = wide_sum[SumBits] ? {1'b1, {(SumBits-1){1'b0}}}
                                  : {1'b0, {(SumBits-1){1'b1}}};
    end else begin
      sat_sum = wide_sum[SumBits-1:0];
    end
  end

  // accumulator, error flag and snapshot on finish
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      error_seen  <= 1'b0;
      snap.valid  <= 1'b0;
    end else begin
      snap.valid <= ctl.fin;
      if (ctl.add) begin
        if (ctl.in_range) begin
          running_sum <= sat_sum;
        end else begin
          error_seen <= 1'b1;
        end
      end
      if (ctl.fin) begin
        snap.sum    <= running_sum;
        snap.err    <= error_seen;
        running_sum <= '0;
        error_seen  <= 1'b0;
      end
    end
  end

endmodule

@@ design/sls_sigmoid.sv @@
module sls_sigmoid (
  input  logic                               clk,
  input  logic                               rst,
  input  sls_pkg::snap_t                     snap,
  output logic                               done,
  output logic [sls_pkg::ProbBits-1:0]       probability,
  output logic signed [sls_pkg::SumBits-1:0] raw_sum,
  output logic                               bad_index
);
  import sls_pkg::*;

  // magnitude stage registers
  logic                      a_valid;
  logic                      a_neg;
  logic [4:0]                a_seg;
  logic [14:0]               a_frac;
  logic signed [SumBits-1:0] a_sum;
  logic                      a_err;

  logic [SumBits:0] mag;
  logic [19:0]      clamped;

  // absolute value and clamp to 8.0
  always_comb begin
    mag = snap.sum[SumBits-1] ? -(SumBits+1)'(snap.sum) : (SumBits+1)'(snap.sum);
    if (mag > (SumBits+1)'(SigClamp)) begin
      clamped = SigClamp;
    end else begin
      clamped = mag[19:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= snap.valid;
    end
  end

  always_ff @(posedge clk) begin
    a_neg  <= snap.sum[SumBits-1];
    a_seg  <= clamped[19:15];
    a_frac <= clamped[14:0];
    a_sum  <= snap.sum;
    a_err  <= snap.err;
  end

  logic [15:0] base;
  logic [15:0] upper;
  logic [12:0] diff;
  logic [27:0] prod;
  logic [16:0] mag_prob;
  logic [16:0] prob;

  // table interpolation with round half up, mirrored for negative sums
  always_comb begin
    base  = sig_point(a_seg);
    upper = sig_point(a_seg + 5'd1);
    diff  = 13'(upper - base);
    prod  = 28'(diff) * 28'(a_frac) + 28'd16384;
    if (a_seg >= 5'd16) begin
      mag_prob = 17'(sig_point(5'd16));
    end else begin
      mag_prob = 17'(base) + 17'(prod[27:15]);
    end
    prob = a_neg ? 17'h10000 - mag_prob : mag_prob;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    probability <= prob[ProbBits-1:0];
    raw_sum     <= a_sum;
    bad_index   <= a_err;
  end

endmodule

@@ design/sparse_logistic_scorer.sv @@
// sparse logistic scorer: logistic regression inference over binary features
//
// input: a transaction is taken on each clock edge with start high (busy is
// always low, so one transaction per cycle is sustained). command 0 writes
// weight_value into the weight store at feature_index, command 1 adds the
// stored weight at feature_index to the running sum, command 2 finishes the
// instance, command 3 is ignored.
// configuration: cfg_write with cfg_data loads the feature count; adds at or
// above it are dropped and flag bad_index on the instance's result.
// output: a finish yields one result transaction, done high for one cycle with
// probability (Q0.16), raw_sum (Q16.16) and bad_index. results come out in
// order at up to one per cycle. a finish passes through the decode register
// (alongside the registered read of the weight memory), the accumulate register
// and the two sigmoid stages (clamp, then table interpolation) before done.
// the receiver cannot stall; results are never held back.
// reset clears the sum, the error flag, the pipeline and sets the feature
// count to 65536; weight memory contents are kept and must be written first.
module sparse_logistic_scorer #(
  parameter int MAX_FEATURES = sls_pkg::MaxFeaturesDefault,
  parameter int WEIGHT_BITS  = sls_pkg::WeightBitsDefault
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  output logic                                    busy,
  input  logic [1:0]                              command,
  input  logic [sls_pkg::IndexBits-1:0]           feature_index,
  input  logic signed [sls_pkg::InWeightBits-1:0] weight_value,
  input  logic                                    cfg_write,
  input  logic [sls_pkg::CountBits-1:0]           cfg_data,
  output logic                                    done,
  output logic [sls_pkg::ProbBits-1:0]            probability,
  output logic signed [sls_pkg::SumBits-1:0]      raw_sum,
  output logic                                    bad_index
);
  import sls_pkg::*;

  localparam int AddrBits = $clog2(MAX_FEATURES);
  localparam longint WeightHi = (64'sd1 <<< (WEIGHT_BITS - 1)) - 64'sd1;
  localparam longint WeightLo = -WeightHi - 64'sd1;

  logic [CountBits-1:0] features_in_use;

  cmd_t                          cmd;
  logic                          accept;
  logic                          below_max;
  logic [AddrBits-1:0]           addr;
  logic signed [WEIGHT_BITS-1:0] wdata;
  logic signed [WEIGHT_BITS-1:0] rdata;
  acc_ctl_t                      ctl;
  acc_ctl_t                      ctl_next;
  snap_t                         snap;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign cmd    = cmd_t'(command);
  assign below_max = 32'(feature_index) < 32'(MAX_FEATURES);
  assign addr   = AddrBits'(feature_index);

  // feature count register
  always_ff @(posedge clk) begin
    if (rst) begin
      features_in_use <= FeatureCountReset;
    end else if (cfg_write) begin
      features_in_use <= cfg_data;
    end
  end

  // fit the written weight to the stored width
  always_comb begin
    if (WEIGHT_BITS < InWeightBits) begin
      if (longint'(weight_value) > WeightHi) begin
        wdata = WEIGHT_BITS'(WeightHi);
      end else if (longint'(weight_value) < WeightLo) begin
        wdata = WEIGHT_BITS'(WeightLo);
      end else begin
        wdata = WEIGHT_BITS'(weight_value);
      end
    end else begin
      wdata = WEIGHT_BITS'(weight_value);
    end
  end

  // decode the transaction into accumulate controls
  always_comb begin
    ctl_next = '0;
    case (cmd)
      CMD_ADD: begin
        ctl_next.add      = accept;
        ctl_next.in_range = below_max &&
                            (CountBits'(feature_index) < features_in_use);
      end
      CMD_FINISH: begin
        ctl_next.fin = accept;
      end
      default: begin
        ctl_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl <= ctl_next;
    end
  end

  // weight memory, read lines up with the accumulate stage
  sls_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (MAX_FEATURES)
  ) u_weights (
    .clk   (clk),
    .we    (accept && (cmd == CMD_WRITE) && below_max),
    .waddr (addr),
    .wdata (wdata),
    .raddr (addr),
    .rdata (rdata)
  );

  sls_accum #(
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_accum (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .weight (rdata),
    .snap   (snap)
  );

  sls_sigmoid u_sigmoid (
    .clk         (clk),
    .rst         (rst),
    .snap        (snap),
    .done        (done),
    .probability (probability),
    .raw_sum     (raw_sum),
    .bad_index   (bad_index)
  );

endmodule
